### sv/cmu_pkg.sv
// ----------------------------------------------------------------------------
// cmu_pkg
// Shared types, widths and weight arithmetic for the cluster membership table.
// ----------------------------------------------------------------------------
package cmu_pkg;

  localparam int NODES = 1024;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int NW_W  = 32;
  localparam int CW_W  = 42;

  localparam logic [NW_W-1:0] WEIGHT_ONE = NW_W'(65536);
  localparam logic [CW_W-1:0] CW_MAX     = {CW_W{1'b1}};

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_SINGLE = 3'd1,
    ACT_STAGE  = 3'd2,
    ACT_COMMIT = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  // per-node entry
  typedef struct packed {
    logic [NW_W-1:0]  weight;
    logic [IDX_W-1:0] cof;
    logic             sv;
    logic [IDX_W-1:0] st;
    logic             sn;
  } node_t;

  // per-cluster entry
  typedef struct packed {
    logic [CNT_W-1:0] size;
    logic [CW_W-1:0]  cw;
    logic             mark;
  } clus_t;

  function automatic logic [CW_W-1:0] cw_add(logic [CW_W-1:0] cw, logic [NW_W-1:0] w);
    logic [CW_W:0] s;
    s = {1'b0, cw} + (CW_W+1)'(w);
    return s[CW_W] ? CW_MAX : s[CW_W-1:0];
  endfunction

  function automatic logic [CW_W-1:0] cw_sub(logic [CW_W-1:0] cw, logic [NW_W-1:0] w);
    return (cw >= CW_W'(w)) ? cw - CW_W'(w) : '0;
  endfunction

endpackage

### sv/cluster_membership_update.sv
// ----------------------------------------------------------------------------
// cluster_membership_update
// Node-to-cluster table with per-cluster size, weight and modified mark.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears with done high for one cycle and cannot be held off. The state
// lives in two single-read-port RAMs (node table, cluster table), so every
// step is a chain of dependent reads: write weight, stage and query read
// the node entry, then its cluster entry, then register the result. Reset
// to singletons walks the node table, rewriting each node and its own
// cluster entry. A commit makes four sweeps: mark clear, leave, join and
// new-cluster placement, whose lowest-empty-id search only moves upward
// within a commit. Both then answer like a query. After rst the block
// runs an initializing pass over both tables with busy high.
module cluster_membership_update (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                action,
  input  logic [cmu_pkg::IDX_W-1:0] node_index,
  input  logic [cmu_pkg::IDX_W-1:0] target_cluster,
  input  logic                      to_new_cluster,
  input  logic [cmu_pkg::NW_W-1:0]  weight_value,
  output logic                      done,
  output logic [cmu_pkg::IDX_W-1:0] cluster_num,
  output logic [cmu_pkg::CNT_W-1:0] member_count,
  output logic [cmu_pkg::CW_W-1:0]  total_weight,
  output logic                      was_modified
);
  import cmu_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_NRD, S_NDAT, S_CDAT,
    S_SG_RD, S_SG_NDAT, S_SG_CDAT,
    S_CLR_RD, S_CLR_DAT,
    S_P1_RD, S_P1_NDAT, S_P1_CDAT,
    S_P2_RD, S_P2_NDAT, S_P2_CDAT,
    S_P3_RD, S_P3_NDAT, S_P3_SCAN, S_P3_SDAT, S_P3_FBRD, S_P3_FB
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] p;
  node_t            nd;
  logic [2:0]       act;
  logic [IDX_W-1:0] nidx;
  logic [IDX_W-1:0] tgt;
  logic             tonew;
  logic [NW_W-1:0]  wval;

  logic             n_we, c_we;
  logic [IDX_W-1:0] n_waddr, n_raddr, c_waddr, c_raddr;
  node_t            n_wdata, n_rdata;
  clus_t            c_wdata, c_rdata;

  logic last;
  logic mv1, mv2, mv3;

  assign busy = (state != S_IDLE);
  assign last = (idx == CNT_W'(NODES - 1));
  assign mv1  = n_rdata.sv && (n_rdata.sn || n_rdata.st != n_rdata.cof);
  assign mv2  = n_rdata.sv && !n_rdata.sn && n_rdata.st != n_rdata.cof;
  assign mv3  = n_rdata.sv && n_rdata.sn;

  cmu_ram #(.WIDTH($bits(node_t)), .DEPTH(NODES)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  cmu_ram #(.WIDTH($bits(clus_t)), .DEPTH(NODES)) u_clus_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // memory port control
  always_comb begin
    n_we    = 1'b0;
    n_waddr = idx[IDX_W-1:0];
    n_wdata = n_rdata;
    n_raddr = idx[IDX_W-1:0];
    c_we    = 1'b0;
    c_waddr = idx[IDX_W-1:0];
    c_wdata = c_rdata;
    c_raddr = idx[IDX_W-1:0];
    unique case (state)
      S_INIT: begin
        n_we    = 1'b1;
        n_wdata = '{weight: WEIGHT_ONE, cof: idx[IDX_W-1:0], sv: 1'b0, st: '0, sn: 1'b0};
        c_we    = 1'b1;
        c_wdata = '{size: CNT_W'(1), cw: CW_W'(WEIGHT_ONE), mark: 1'b0};
      end
      S_IDLE: n_raddr = node_index;
      S_NRD:  n_raddr = nidx;
      S_NDAT: begin
        n_waddr = nidx;
        c_raddr = n_rdata.cof;
        if (act == ACT_WRITE) begin
          n_we           = 1'b1;
          n_wdata.weight = wval;
        end else if (act == ACT_STAGE && (tonew || int'(tgt) < NODES)) begin
          n_we       = 1'b1;
          n_wdata.sv = 1'b1;
          n_wdata.sn = tonew;
          n_wdata.st = tonew ? '0 : tgt;
        end
      end
      S_SG_NDAT: begin
        n_we        = 1'b1;
        n_wdata.cof = idx[IDX_W-1:0];
      end
      S_SG_CDAT: begin
        c_we    = 1'b1;
        c_wdata = '{size: CNT_W'(1), cw: CW_W'(nd.weight), mark: c_rdata.mark};
      end
      S_CLR_DAT: begin
        c_we         = 1'b1;
        c_wdata.mark = 1'b0;
      end
      S_P1_NDAT: c_raddr = n_rdata.cof;
      S_P1_CDAT: begin
        c_we    = 1'b1;
        c_waddr = nd.cof;
        c_wdata = '{size: (c_rdata.size != '0) ? c_rdata.size - CNT_W'(1) : c_rdata.size,
                    cw: cw_sub(c_rdata.cw, nd.weight), mark: 1'b1};
      end
      S_P2_NDAT: begin
        c_raddr = n_rdata.st;
        if (mv2) begin
          n_we        = 1'b1;
          n_wdata.cof = n_rdata.st;
        end
      end
      S_P2_CDAT: begin
        c_we    = 1'b1;
        c_waddr = nd.st;
        c_wdata = '{size: c_rdata.size + CNT_W'(1), cw: cw_add(c_rdata.cw, nd.weight),
                    mark: 1'b1};
      end
      S_P3_NDAT: begin
        // staged moves are dropped as each node is passed
        n_we       = 1'b1;
        n_wdata.sv = 1'b0;
      end
      S_P3_SCAN: c_raddr = p[IDX_W-1:0];
      S_P3_SDAT: begin
        c_waddr = p[IDX_W-1:0];
        n_wdata = nd;
        n_wdata.sv  = 1'b0;
        n_wdata.cof = p[IDX_W-1:0];
        c_wdata = '{size: CNT_W'(1), cw: CW_W'(nd.weight), mark: 1'b1};
        if (c_rdata.size == '0) begin
          n_we = 1'b1;
          c_we = 1'b1;
        end
      end
      S_P3_FBRD: c_raddr = nd.cof;
      S_P3_FB: begin
        c_we    = 1'b1;
        c_waddr = nd.cof;
        c_wdata = '{size: c_rdata.size + CNT_W'(1), cw: cw_add(c_rdata.cw, nd.weight),
                    mark: 1'b1};
      end
      S_CDAT, S_SG_RD, S_CLR_RD, S_P1_RD, S_P2_RD, S_P3_RD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
      p     <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          idx   <= last ? '0 : idx + CNT_W'(1);
          state <= last ? S_IDLE : S_INIT;
        end
        S_IDLE: begin
          if (start) begin
            act   <= action;
            nidx  <= node_index;
            tgt   <= target_cluster;
            tonew <= to_new_cluster;
            wval  <= weight_value;
            idx   <= '0;
            if (action == ACT_SINGLE) begin
              state <= S_SG_RD;
            end else if (action == ACT_COMMIT) begin
              state <= S_CLR_RD;
            end else begin
              state <= S_NDAT;
            end
          end
        end
        S_NRD: state <= S_NDAT;
        S_NDAT: begin
          nd    <= n_rdata;
          state <= S_CDAT;
        end
        S_CDAT: begin
          done         <= 1'b1;
          cluster_num  <= nd.cof;
          member_count <= c_rdata.size;
          total_weight <= c_rdata.cw;
          was_modified <= c_rdata.mark;
          state        <= S_IDLE;
        end
        S_SG_RD: state <= S_SG_NDAT;
        S_SG_NDAT: begin
          nd    <= n_rdata;
          state <= S_SG_CDAT;
        end
        S_SG_CDAT: begin
          idx   <= last ? '0 : idx + CNT_W'(1);
          state <= last ? S_NRD : S_SG_RD;
        end
        S_CLR_RD: state <= S_CLR_DAT;
        S_CLR_DAT: begin
          idx   <= last ? '0 : idx + CNT_W'(1);
          state <= last ? S_P1_RD : S_CLR_RD;
        end
        S_P1_RD: state <= S_P1_NDAT;
        S_P1_NDAT: begin
          nd <= n_rdata;
          if (mv1) begin
            state <= S_P1_CDAT;
          end else begin
            idx   <= last ? '0 : idx + CNT_W'(1);
            state <= last ? S_P2_RD : S_P1_RD;
          end
        end
        S_P1_CDAT: begin
          idx   <= last ? '0 : idx + CNT_W'(1);
          state <= last ? S_P2_RD : S_P1_RD;
        end
        S_P2_RD: state <= S_P2_NDAT;
        S_P2_NDAT: begin
          nd <= n_rdata;
          if (mv2) begin
            state <= S_P2_CDAT;
          end else begin
            idx   <= last ? '0 : idx + CNT_W'(1);
            p     <= '0;
            state <= last ? S_P3_RD : S_P2_RD;
          end
        end
        S_P2_CDAT: begin
          idx   <= last ? '0 : idx + CNT_W'(1);
          p     <= '0;
          state <= last ? S_P3_RD : S_P2_RD;
        end
        S_P3_RD: state <= S_P3_NDAT;
        S_P3_NDAT: begin
          nd <= n_rdata;
          if (mv3) begin
            // the lowest empty id only rises during placement
            state <= (p == CNT_W'(NODES)) ? S_P3_FBRD : S_P3_SCAN;
          end else begin
            idx   <= last ? '0 : idx + CNT_W'(1);
            state <= last ? S_NRD : S_P3_RD;
          end
        end
        S_P3_SCAN: state <= S_P3_SDAT;
        S_P3_SDAT: begin
          p <= p + CNT_W'(1);
          if (c_rdata.size == '0) begin
            idx   <= last ? '0 : idx + CNT_W'(1);
            state <= last ? S_NRD : S_P3_RD;
          end else begin
            state <= (p == CNT_W'(NODES - 1)) ? S_P3_FBRD : S_P3_SCAN;
          end
        end
        S_P3_FBRD: state <= S_P3_FB;
        S_P3_FB: begin
          idx   <= last ? '0 : idx + CNT_W'(1);
          state <= last ? S_NRD : S_P3_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/cmu_ram.sv
// ----------------------------------------------------------------------------
// cmu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cluster_membership_update: directed and random
// requests, a local table model predicts every result, results are compared
// field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmu_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [IDX_W-1:0] cid;
    logic [CNT_W-1:0] cnt;
    logic [CW_W-1:0]  wsum;
    logic             mod;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] action = '0;
  logic [IDX_W-1:0] node_index = '0;
  logic [IDX_W-1:0] target_cluster = '0;
  logic to_new_cluster = 1'b0;
  logic [NW_W-1:0] weight_value = '0;
  logic busy, done, was_modified;
  logic [IDX_W-1:0] cluster_num;
  logic [CNT_W-1:0] member_count;
  logic [CW_W-1:0] total_weight;

  // table copy
  logic [NW_W-1:0]  m_weight [NODES];
  logic [IDX_W-1:0] m_cof    [NODES];
  logic [CNT_W-1:0] m_size   [NODES];
  logic [CW_W-1:0]  m_cw     [NODES];
  logic             m_mark   [NODES];
  logic             m_sv     [NODES];
  logic [IDX_W-1:0] m_st     [NODES];
  logic             m_sn     [NODES];

  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  cluster_membership_update dut (.*);

  function automatic logic [CW_W-1:0] sat_add(logic [CW_W-1:0] a, logic [NW_W-1:0] w);
    logic [CW_W:0] s;
    s = {1'b0, a} + {{(CW_W+1-NW_W){1'b0}}, w};
    return s[CW_W] ? {CW_W{1'b1}} : s[CW_W-1:0];
  endfunction

  task automatic table_reset();
    for (int i = 0; i < NODES; i++) begin
      m_weight[i] = WEIGHT_ONE;
      m_mark[i] = 1'b0;
      m_sv[i] = 1'b0;
      m_st[i] = '0;
      m_sn[i] = 1'b0;
    end
    make_singletons();
  endtask

  task automatic make_singletons();
    for (int i = 0; i < NODES; i++) begin
      m_cof[i] = IDX_W'(i);
      m_size[i] = CNT_W'(1);
      m_cw[i] = CW_W'(m_weight[i]);
    end
  endtask

  task automatic apply_commit();
    logic mv [NODES];
    int c;
    for (int i = 0; i < NODES; i++) m_mark[i] = 1'b0;
    for (int n = 0; n < NODES; n++) begin
      mv[n] = m_sv[n] && (m_sn[n] || m_st[n] != m_cof[n]);
      if (mv[n]) begin
        c = int'(m_cof[n]);
        if (m_size[c] != 0) m_size[c]--;
        m_cw[c] = (m_cw[c] >= CW_W'(m_weight[n])) ? m_cw[c] - CW_W'(m_weight[n]) : '0;
        m_mark[c] = 1'b1;
      end
    end
    for (int n = 0; n < NODES; n++)
      if (mv[n] && !m_sn[n]) begin
        c = int'(m_st[n]);
        m_cof[n] = m_st[n];
        m_size[c]++;
        m_cw[c] = sat_add(m_cw[c], m_weight[n]);
        m_mark[c] = 1'b1;
      end
    for (int n = 0; n < NODES; n++) begin
      if (!mv[n] || !m_sn[n]) continue;
      c = 0;
      while (c < NODES && m_size[c] != 0) c++;
      if (c < NODES) begin
        m_cof[n] = IDX_W'(c);
        m_size[c] = CNT_W'(1);
        m_cw[c] = CW_W'(m_weight[n]);
        m_mark[c] = 1'b1;
      end else begin
        c = int'(m_cof[n]);
        m_size[c]++;
        m_cw[c] = sat_add(m_cw[c], m_weight[n]);
        m_mark[c] = 1'b1;
      end
    end
    for (int i = 0; i < NODES; i++) m_sv[i] = 1'b0;
  endtask

  task automatic predict_step(logic [2:0] a, logic [IDX_W-1:0] n, logic [IDX_W-1:0] t,
                              logic nw, logic [NW_W-1:0] w);
    answer_t r;
    logic [IDX_W-1:0] c;
    case (a)
      ACT_WRITE: m_weight[n] = w;
      ACT_SINGLE: make_singletons();
      ACT_STAGE: begin
        m_sv[n] = 1'b1;
        m_sn[n] = nw;
        m_st[n] = nw ? '0 : t;
      end
      ACT_COMMIT: apply_commit();
      default: ;
    endcase
    c = m_cof[n];
    r.cid = c;
    r.cnt = m_size[c];
    r.wsum = m_cw[c];
    r.mod = m_mark[c];
    pending_answers.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one request, at times after a random idle gap
  task automatic send_request(logic [2:0] a, logic [IDX_W-1:0] n, logic [IDX_W-1:0] t,
                              logic nw, logic [NW_W-1:0] w);
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    action <= a;
    node_index <= n;
    target_cluster <= t;
    to_new_cluster <= nw;
    weight_value <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_step(a, n, t, nw, w);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic rand_request();
    int p;
    logic [NW_W-1:0] w;
    p = $urandom_range(0, 99);
    w = ($urandom_range(0, 7) == 0) ? $urandom : NW_W'($urandom_range(0, 4)) << 16;
    if (p < 12) send_request(ACT_WRITE, IDX_W'($urandom_range(0, 31)), '0, 1'b0, w);
    else if (p < 55) send_request(ACT_STAGE, IDX_W'($urandom_range(0, 31)),
                                  ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                                              : IDX_W'($urandom_range(0, 31)),
                                  $urandom_range(0, 3) == 0, $urandom);
    else if (p < 58) send_request(ACT_COMMIT, IDX_W'($urandom), IDX_W'($urandom),
                                  1'($urandom), $urandom);
    else if (p < 59) send_request(ACT_SINGLE, IDX_W'($urandom), IDX_W'($urandom),
                                  1'($urandom), $urandom);
    else if (p < 62) send_request(3'($urandom_range(5, 7)), IDX_W'($urandom),
                                  IDX_W'($urandom), 1'($urandom), $urandom);
    else send_request(ACT_QUERY, ($urandom_range(0, 4) == 0) ? IDX_W'($urandom)
                                                             : IDX_W'($urandom_range(0, 31)),
                      IDX_W'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic test_weights();
    send_request(ACT_WRITE, 0, 0, 1'b0, 32'hFFFF_FFFF);
    send_request(ACT_WRITE, 1023, 1023, 1'b1, 32'h0);
    send_request(ACT_WRITE, 5, 0, 1'b0, 32'h0003_0000);
    send_request(ACT_QUERY, 0, 0, 1'b0, 0);
    send_request(ACT_SINGLE, 0, 0, 1'b0, 0);
    send_request(ACT_QUERY, 1023, 0, 1'b0, 0);
  endtask

  task automatic test_moves();
    send_request(ACT_STAGE, 0, 5, 1'b0, 0);
    send_request(ACT_STAGE, 1, 5, 1'b0, 0);
    send_request(ACT_STAGE, 5, 5, 1'b0, 0);     // target is own cluster: not a mover
    send_request(ACT_STAGE, 2, 1023, 1'b0, 0);
    send_request(ACT_STAGE, 2, 7, 1'b0, 0);     // later stage overwrites
    send_request(ACT_COMMIT, 0, 0, 1'b0, 0);
    send_request(ACT_STAGE, 0, 0, 1'b1, 0);
    send_request(ACT_STAGE, 3, 900, 1'b1, 0);
    send_request(ACT_COMMIT, 3, 0, 1'b0, 0);
    send_request(ACT_QUERY, 1, 0, 1'b0, 0);
    send_request(3'd7, 0, 0, 1'b0, 0);
    // moving a heavy node out of a light cluster saturates the weight at zero
    send_request(ACT_WRITE, 5, 0, 1'b0, 32'hFFFF_FFFF);
    send_request(ACT_STAGE, 5, 9, 1'b0, 0);
    send_request(ACT_COMMIT, 5, 0, 1'b0, 0);
    send_request(ACT_QUERY, 0, 0, 1'b0, 0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1930; i++) begin
      rand_request();
      if (i == 900) wait_drained();
    end
    send_request(ACT_SINGLE, 0, 0, 1'b0, 0);
  endtask

  initial begin
    table_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_weights();
    test_moves();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", longint'(cluster_num), 0);
      end else begin
        e = pending_answers.pop_front();
        if (cluster_num !== e.cid)
          report_mismatch("cluster_num", longint'(cluster_num), longint'(e.cid));
        if (member_count !== e.cnt)
          report_mismatch("member_count", longint'(member_count), longint'(e.cnt));
        if (total_weight !== e.wsum)
          report_mismatch("total_weight", longint'(total_weight), longint'(e.wsum));
        if (was_modified !== e.mod)
          report_mismatch("was_modified", longint'(was_modified), longint'(e.mod));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end
endmodule
